// ===== rtl/distinct_multiplicity_table_top_defines.svh =====
// Assertion macros used by the RTL file dmt_back.
`ifndef DISTINCT_MULTIPLICITY_TABLE_TOP_DEFINES_SVH
`define DISTINCT_MULTIPLICITY_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmt assertion failed");
// Next-cycle implication.
`define DMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmt assertion failed");
`else
`define DMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define DMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/dmt_pkg.sv =====
`timescale 1ns / 1ps
package dmt_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_KEY_BITS      = 32;
    localparam int DEF_COUNT_BITS    = 16;
    localparam int DEF_TIME_BITS     = 32;

    localparam int KEY_PORT_W  = 32;
    localparam int TIME_PORT_W = 32;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OPC_HEARTBEAT = 2'd0,
        OPC_INSERT    = 2'd1,
        OPC_DELETE    = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_INSERT    = 2'd0,
        KIND_DELETE    = 2'd1,
        KIND_HEARTBEAT = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_UNKNOWN = 2'd2
    } err_t;

endpackage

// ===== rtl/distinct_multiplicity_table_top.sv =====
`timescale 1ns / 1ps
// Flow: items wait in the queue and pass the back one at a time: it registers the
//   match vector and lowest free entry, then updates the cells and loads the result
//   register, waiting on a stalled result; the two-entry queue takes items meanwhile.
// Reset: rst_n asynchronous, active low; clears all entry valid bits, the last
//   output time, the queue and the output valid bit. No clearing pass is needed.
module distinct_multiplicity_table_top #(
    parameter int TABLE_ENTRIES = dmt_pkg::DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = dmt_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS    = dmt_pkg::DEF_COUNT_BITS,
    parameter int TIME_BITS     = dmt_pkg::DEF_TIME_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [dmt_pkg::KEY_PORT_W-1:0]    tuple_key,
    input  logic [dmt_pkg::TIME_PORT_W-1:0]   event_time,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        out_kind,
    output logic [dmt_pkg::KEY_PORT_W-1:0]    out_key,
    output logic [dmt_pkg::TIME_PORT_W-1:0]   out_time,
    output logic [1:0]                        error_code
);
    import dmt_pkg::*;

    // keys and times compare in their low KEY_BITS / TIME_BITS bits,
    // never wider than the 32-bit ports
    localparam int KEY_W  = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int TIME_W = (TIME_BITS < TIME_PORT_W) ? TIME_BITS : TIME_PORT_W;

    logic              q_valid;
    opcode_t           q_op;
    logic [KEY_W-1:0]  q_key;
    logic [TIME_W-1:0] q_time;
    logic              q_pop;

    // Front: takes items, drops the unused opcode, narrows the fields and
    // queues the rest. Stalls only when the queue is full.
    dmt_front #(
        .KEY_W  (KEY_W),
        .TIME_W (TIME_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .tuple_key  (tuple_key),
        .event_time (event_time),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .q_key      (q_key),
        .q_time     (q_time),
        .q_pop      (q_pop)
    );

    // Back: associative table. The match step registers the match vector and
    // the lowest free entry; the update step updates the cells and loads the
    // result register; it waits while a stalled result blocks a new one.
    dmt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_W         (KEY_W),
        .COUNT_W       (COUNT_BITS),
        .TIME_W        (TIME_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .q_key      (q_key),
        .q_time     (q_time),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_kind   (out_kind),
        .out_key    (out_key),
        .out_time   (out_time),
        .error_code (error_code)
    );

endmodule

// ===== rtl/dmt_front.sv =====
`timescale 1ns / 1ps
module dmt_front #(
    parameter int KEY_W  = dmt_pkg::DEF_KEY_BITS,
    parameter int TIME_W = dmt_pkg::DEF_TIME_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [dmt_pkg::KEY_PORT_W-1:0]    tuple_key,
    input  logic [dmt_pkg::TIME_PORT_W-1:0]   event_time,
    output logic                              q_valid,
    output dmt_pkg::opcode_t                  q_op,
    output logic [KEY_W-1:0]                  q_key,
    output logic [TIME_W-1:0]                 q_time,
    input  logic                              q_pop
);
    import dmt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    opcode_t           op_mem   [QUEUE_DEPTH];
    logic [KEY_W-1:0]  key_mem  [QUEUE_DEPTH];
    logic [TIME_W-1:0] time_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic accept;
    logic known_op;
    logic push;

    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    // opcode three is taken and dropped here
    assign known_op = (opcode == OPC_HEARTBEAT) || (opcode == OPC_INSERT) ||
                      (opcode == OPC_DELETE);
    assign push     = accept && known_op;

    assign q_valid = (count_reg != '0);
    assign q_op    = op_mem[rd_ptr_reg];
    assign q_key   = key_mem[rd_ptr_reg];
    assign q_time  = time_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // key and time narrowed to their compare widths on entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]   <= opcode_t'(opcode);
            key_mem[wr_ptr_reg]  <= tuple_key[KEY_W-1:0];
            time_mem[wr_ptr_reg] <= event_time[TIME_W-1:0];
        end
    end

endmodule

// ===== rtl/dmt_back.sv =====
`timescale 1ns / 1ps
`include "distinct_multiplicity_table_top_defines.svh"
module dmt_back #(
    parameter int TABLE_ENTRIES = dmt_pkg::DEF_TABLE_ENTRIES,
    parameter int KEY_W         = dmt_pkg::DEF_KEY_BITS,
    parameter int COUNT_W       = dmt_pkg::DEF_COUNT_BITS,
    parameter int TIME_W        = dmt_pkg::DEF_TIME_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  dmt_pkg::opcode_t                  q_op,
    input  logic [KEY_W-1:0]                  q_key,
    input  logic [TIME_W-1:0]                 q_time,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        out_kind,
    output logic [dmt_pkg::KEY_PORT_W-1:0]    out_key,
    output logic [dmt_pkg::TIME_PORT_W-1:0]   out_time,
    output logic [1:0]                        error_code
);
    import dmt_pkg::*;

    localparam int N = TABLE_ENTRIES;

    typedef enum logic [1:0] {
        ST_MATCH = 2'b01,
        ST_EXEC  = 2'b10
    } state_t;

    state_t st_reg, st_next;

    // table cells
    logic [N-1:0]       valid_reg, valid_next;
    logic [KEY_W-1:0]   entry_key_reg   [N];
    logic [KEY_W-1:0]   entry_key_next  [N];
    logic [COUNT_W-1:0] entry_cnt_reg   [N];
    logic [COUNT_W-1:0] entry_cnt_next  [N];
    logic [TIME_W-1:0]  last_time_reg, last_time_next;

    // item under execution and its lookup result
    opcode_t            item_op_reg;
    logic [KEY_W-1:0]   item_key_reg;
    logic [TIME_W-1:0]  item_time_reg;
    logic [N-1:0]       match_reg, match_next;
    logic [N-1:0]       free_reg, free_next;
    logic [N-1:0]       free_vec;
    logic [N-1:0]       le1_vec;

    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg;
    err_t               out_err_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic [TIME_W-1:0]  out_time_reg;

    logic  hit, one_hit, full, hb_new;
    logic  emit;
    kind_t kind;
    err_t  err;
    logic  out_free;
    logic  exec_go;

    localparam logic [COUNT_W-1:0] CNT_MAX = '1;

    // lookup: parallel compare, lowest free entry as one-hot
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match_next[i] = valid_reg[i] && (entry_key_reg[i] == q_key);
            le1_vec[i]    = (entry_cnt_reg[i] <= COUNT_W'(1));
        end
        free_vec  = ~valid_reg;
        free_next = free_vec & (~free_vec + 1'b1);
    end

    assign q_pop = (st_reg == ST_MATCH) && q_valid;

    always_comb
    begin
        hit     = |match_reg;
        one_hit = |(match_reg & le1_vec);
        full    = ~|free_reg;
        hb_new  = (item_time_reg > last_time_reg);
        emit    = 1'b0;
        kind    = KIND_HEARTBEAT;
        err     = ERR_NONE;
        case (item_op_reg)
            OPC_HEARTBEAT:
            begin
                emit = hb_new;
                kind = KIND_HEARTBEAT;
            end
            OPC_INSERT:
            begin
                emit = !hit;
                kind = full ? KIND_ERROR : KIND_INSERT;
                err  = full ? ERR_FULL : ERR_NONE;
            end
            OPC_DELETE:
            begin
                emit = !hit || one_hit;
                kind = hit ? KIND_DELETE : KIND_ERROR;
                err  = hit ? ERR_NONE : ERR_UNKNOWN;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign exec_go  = (st_reg == ST_EXEC) && (!emit || out_free);

    // per-cell update
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < N; i++)
        begin
            entry_key_next[i] = entry_key_reg[i];
            entry_cnt_next[i] = entry_cnt_reg[i];
            if (exec_go)
            begin
                if (item_op_reg == OPC_INSERT && hit && match_reg[i])
                begin
                    if (entry_cnt_reg[i] != CNT_MAX)
                    begin
                        entry_cnt_next[i] = entry_cnt_reg[i] + 1'b1;
                    end
                end
                else if (item_op_reg == OPC_INSERT && !hit && free_reg[i])
                begin
                    entry_key_next[i] = item_key_reg;
                    entry_cnt_next[i] = COUNT_W'(1);
                    valid_next[i]     = 1'b1;
                end
                else if (item_op_reg == OPC_DELETE && match_reg[i])
                begin
                    if (le1_vec[i])
                    begin
                        valid_next[i] = 1'b0;
                    end
                    else
                    begin
                        entry_cnt_next[i] = entry_cnt_reg[i] - 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        last_time_next = last_time_reg;
        if (exec_go && emit && kind != KIND_ERROR)
        begin
            last_time_next = item_time_reg;
        end
        out_valid_next = out_valid_reg;
        if (exec_go && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_MATCH:
            begin
                if (q_valid)
                begin
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    st_next = ST_MATCH;
                end
            end
            default:
            begin
                st_next = ST_MATCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_MATCH;
            valid_reg     <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            valid_reg     <= valid_next;
            last_time_reg <= last_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            entry_key_reg[i] <= entry_key_next[i];
            entry_cnt_reg[i] <= entry_cnt_next[i];
        end
        if (q_pop)
        begin
            item_op_reg   <= q_op;
            item_key_reg  <= q_key;
            item_time_reg <= q_time;
            match_reg     <= match_next;
            free_reg      <= free_next;
        end
        if (exec_go && emit)
        begin
            out_kind_reg <= kind;
            out_err_reg  <= err;
            out_key_reg  <= (item_op_reg == OPC_HEARTBEAT) ? '0 : item_key_reg;
            out_time_reg <= item_time_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign error_code = out_err_reg;
    assign out_key    = KEY_PORT_W'(out_key_reg);
    assign out_time   = TIME_PORT_W'(out_time_reg);

    // a key lives in at most one entry
    `DMT_ASSERT_SAME(a_match_unique, clk, rst_n, st_reg == ST_EXEC, $onehot0(match_reg))
    `DMT_ASSERT_SAME(a_free_onehot, clk, rst_n, st_reg == ST_EXEC, $onehot0(free_reg))
    // freeing delete drops exactly one entry
    `DMT_ASSERT_NEXT(a_delete_frees, clk, rst_n, exec_go && item_op_reg == OPC_DELETE && one_hit, $countones(valid_reg) + 1 == $past($countones(valid_reg)))
    `DMT_ASSERT_NEXT(a_hb_time, clk, rst_n, exec_go && emit && item_op_reg == OPC_HEARTBEAT, last_time_reg == $past(item_time_reg))

endmodule

// ===== tb/distinct_multiplicity_table_top_tb.sv =====
`timescale 1ns / 1ps
module distinct_multiplicity_table_top_tb;
    import dmt_pkg::*;

    // Opcode three is not decoded by the block; it must be dropped silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SLOTS     = DEF_TABLE_ENTRIES;
    localparam int COUNT_TOP = (1 << DEF_COUNT_BITS) - 1;
    localparam int POOL_KEYS = 12;
    localparam int BURST_LEN = 70;
    localparam int HOLD_LEN  = 200;
    localparam int MULT_LEN  = 10;

    // One event offered to the block, plus a flag that suppresses the idle gap after it.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] tkey;
        logic [31:0] stamp;
        bit          quick;
    } tuple_event_t;

    // One result the table is due to emit.
    typedef struct {
        kind_t       kind;
        logic [31:0] tkey;
        logic [31:0] stamp;
        err_t        err;
    } emission_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode     = OPC_HEARTBEAT;
    logic [31:0] tuple_key  = '0;
    logic [31:0] event_time = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [1:0]  out_kind;
    logic [31:0] out_key;
    logic [31:0] out_time;
    logic [1:0]  error_code;

    // Mirror of the distinct table: key, in-use flag and multiplicity per slot.
    logic [31:0] slot_key   [SLOTS];
    bit          slot_used  [SLOTS];
    logic [15:0] slot_count [SLOTS];
    logic [31:0] last_out_time;

    tuple_event_t tuple_events_q [$];  // items not yet handed to the driver
    emission_t    emissions_q    [$];  // results owed by the block, oldest first
    int           events_pending = 0;  // queued or offered, not yet accepted
    int           mismatches     = 0;

    bit          in_taken  = 1'b0;     // item on the bus was accepted at the last rise
    int          gap_left  = 0;
    int          stall_left = 0;
    int          hold_left  = 0;
    int          hold_asked = 0;       // bumped by the stimulus to request a long hold
    int          hold_done  = 0;

    logic [31:0] run_time = 32'd10;
    logic [31:0] key_pool  [POOL_KEYS];
    logic [31:0] burst_keys[BURST_LEN];

    distinct_multiplicity_table_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .tuple_key  (tuple_key),
        .event_time (event_time),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_kind   (out_kind),
        .out_key    (out_key),
        .out_time   (out_time),
        .error_code (error_code)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Table mirror. Applies one accepted event and says whether it emits.
    // ------------------------------------------------------------------
    function automatic bit distinct_update(input logic [1:0] op, input logic [31:0] k,
                                           input logic [31:0] t, output emission_t em);
        int hit;
        int free_slot;
        hit       = -1;
        free_slot = -1;
        em        = '{kind: KIND_ERROR, tkey: k, stamp: t, err: ERR_NONE};
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_key[i] == k)
                hit = i;
            if (!slot_used[i])
                free_slot = i;
        end
        case (op)
            OPC_HEARTBEAT:
            begin
                // stale heartbeat: time not past the last emitted one
                if (t <= last_out_time)
                    return 1'b0;
                last_out_time = t;
                em = '{kind: KIND_HEARTBEAT, tkey: '0, stamp: t, err: ERR_NONE};
                return 1'b1;
            end
            OPC_INSERT:
            begin
                if (hit >= 0)
                begin
                    // known key: count up, sticking at the top
                    if (slot_count[hit] != 16'(COUNT_TOP))
                        slot_count[hit]++;
                    return 1'b0;
                end
                if (free_slot < 0)
                begin
                    em.err = ERR_FULL;
                    return 1'b1;
                end
                slot_key[free_slot]   = k;
                slot_count[free_slot] = 16'd1;
                slot_used[free_slot]  = 1'b1;
                last_out_time         = t;
                em.kind               = KIND_INSERT;
                return 1'b1;
            end
            OPC_DELETE:
            begin
                if (hit < 0)
                begin
                    em.err = ERR_UNKNOWN;
                    return 1'b1;
                end
                if (slot_count[hit] <= 16'd1)
                begin
                    slot_used[hit] = 1'b0;
                    last_out_time  = t;
                    em.kind        = KIND_DELETE;
                    return 1'b1;
                end
                slot_count[hit]--;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly nondecreasing times, with the odd jump anywhere (backward too).
    function automatic logic [31:0] next_time();
        if ($urandom_range(0, 19) == 0)
            run_time = $urandom;
        else
            run_time += $urandom_range(0, 3);
        return run_time;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_event(input logic [1:0] op, input logic [31:0] k, t,
                               input bit quick);
        tuple_events_q.push_back('{op: op, tkey: k, stamp: t, quick: quick});
        events_pending++;
    endtask

    // Random event: mostly pool keys so inserts and deletes hit the table.
    task automatic random_event(input bit quick);
        int          r;
        logic [1:0]  op;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = OPC_INSERT;
        else if (r < 75)
            op = OPC_DELETE;
        else if (r < 95)
            op = OPC_HEARTBEAT;
        else
            op = OP_UNUSED;
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                         : 32'($urandom);
        queue_event(op, k, next_time(), quick);
    endtask

    // Sender pause: nothing left to offer and every owed result delivered.
    task automatic wait_idle();
        while (events_pending != 0 || emissions_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge only. An offered item is
    // held until in_taken reports that the last rising edge accepted it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        tuple_event_t ev;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (tuple_events_q.size() != 0)
            begin
                ev = tuple_events_q.pop_front();
                in_valid   <= 1'b1;
                opcode     <= ev.op;
                tuple_key  <= ev.tkey;
                event_time <= ev.stamp;
                gap_left   <= ev.quick ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure. A requested hold wins over random stalls and
    // is counted down here, independent of the stimulus thread.
    always @(negedge clk)
    begin
        int stall_pick;
        if (hold_done != hold_asked)
        begin
            hold_done <= hold_asked;
            hold_left <= HOLD_LEN - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            stall_pick = pick_gap();
            out_stall  <= (stall_pick != 0);
            stall_left <= (stall_pick != 0) ? stall_pick - 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, retire a delivered result against the
    // oldest owed one, then fold an accepted item into the table mirror.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        emission_t em;
        emission_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (emissions_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d key %0h time %0h code %0d",
                           out_kind, out_key, out_time, error_code);
                    mismatches++;
                end
                else
                begin
                    want = emissions_q.pop_front();
                    check_field("out_kind", 32'(want.kind), 32'(out_kind));
                    check_field("out_key", want.tkey, out_key);
                    check_field("out_time", want.stamp, out_time);
                    check_field("error_code", 32'(want.err), 32'(error_code));
                end
            end
            if (in_valid && !in_stall)
            begin
                events_pending--;
                if (distinct_update(opcode, tuple_key, event_time, em))
                    emissions_q.push_back(em);
            end
            in_taken <= in_valid && !in_stall;
        end
        else
            in_taken <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        foreach (slot_used[i])
        begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_count[i] = '0;
        end
        last_out_time = '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: stale heartbeat at time zero, dropped opcode, unknown
        // delete, count up and down, extreme keys and times.
        queue_event(OPC_HEARTBEAT, 32'h0, 32'h0, 1'b0);
        queue_event(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_event(OPC_DELETE, 32'h0, 32'd1, 1'b0);
        queue_event(OPC_INSERT, 32'h0, 32'd2, 1'b0);
        queue_event(OPC_INSERT, 32'h0, 32'd2, 1'b0);
        queue_event(OPC_INSERT, 32'hFFFF_FFFF, 32'd3, 1'b0);
        queue_event(OPC_HEARTBEAT, 32'h1234_5678, 32'd3, 1'b0);
        queue_event(OPC_HEARTBEAT, 32'hFFFF_FFFF, 32'd4, 1'b0);
        queue_event(OPC_DELETE, 32'h0, 32'd5, 1'b0);
        queue_event(OPC_DELETE, 32'h0, 32'd5, 1'b0);
        queue_event(OPC_DELETE, 32'hFFFF_FFFF, 32'd6, 1'b0);
        queue_event(OPC_DELETE, 32'hFFFF_FFFF, 32'd6, 1'b0);
        queue_event(OPC_HEARTBEAT, 32'h0, 32'hFFFF_FFFF, 1'b0);
        queue_event(OPC_HEARTBEAT, 32'h0, 32'hFFFF_FFFF, 1'b0);
        // an insert pulls the last output time back down
        queue_event(OPC_INSERT, 32'hA5A5_A5A5, 32'h0, 1'b0);
        queue_event(OPC_HEARTBEAT, 32'h0, 32'd1, 1'b0);
        queue_event(OPC_DELETE, 32'hA5A5_A5A5, 32'd1, 1'b0);
        wait_idle();

        // Full table: 64 distinct keys (odd multiplier keeps them distinct),
        // then a new key must be refused while a known one still counts up.
        for (int i = 0; i < SLOTS; i++)
            queue_event(OPC_INSERT, 32'h9E37_79B9 * (i + 1), next_time(), 1'b0);
        queue_event(OPC_INSERT, 32'h0, next_time(), 1'b0);
        queue_event(OPC_INSERT, 32'h9E37_79B9 * 4, next_time(), 1'b0);
        queue_event(OPC_DELETE, 32'h9E37_79B9 * 6, next_time(), 1'b0);
        queue_event(OPC_INSERT, 32'h0, next_time(), 1'b0);
        for (int i = 0; i < SLOTS; i++)
            queue_event(OPC_DELETE, 32'h9E37_79B9 * (i + 1), next_time(), 1'b0);
        queue_event(OPC_DELETE, 32'h9E37_79B9 * 4, next_time(), 1'b0);
        queue_event(OPC_DELETE, 32'h0, next_time(), 1'b0);
        wait_idle();

        // Multiplicity: count one key up back to back, then all the way
        // back down; only the final delete frees the entry.
        for (int i = 0; i < MULT_LEN; i++)
            queue_event(OPC_INSERT, 32'h5A5A_0001, 32'd100, 1'b1);
        for (int i = 0; i < MULT_LEN - 1; i++)
            queue_event(OPC_DELETE, 32'h5A5A_0001, 32'd101, 1'b1);
        queue_event(OPC_DELETE, 32'h5A5A_0001, 32'd102, 1'b1);
        wait_idle();

        // Random, plain mix.
        repeat (50) random_event(1'b0);
        wait_idle();

        // Long receiver hold while the sender keeps offering back to back,
        // so the internal queue fills and in_stall rises.
        hold_asked++;
        repeat (30) random_event(1'b1);
        repeat (70) random_event(1'b0);
        wait_idle();

        // Burst of fresh keys on top of the pool: runs into a full table.
        for (int i = 0; i < BURST_LEN; i++)
        begin
            burst_keys[i] = $urandom;
            queue_event(OPC_INSERT, burst_keys[i], next_time(), $urandom_range(0, 1));
        end
        repeat (30) random_event(1'b0);
        wait_idle();

        // Drain the burst keys, interleaved with more random traffic.
        for (int i = 0; i < BURST_LEN; i++)
        begin
            queue_event(OPC_DELETE, burst_keys[i], next_time(), 1'b0);
            if ($urandom_range(0, 3) == 0)
                random_event(1'b0);
        end
        wait_idle();

        repeat (50) random_event($urandom_range(0, 3) == 0);
        wait_idle();

        // Let the pipeline empty of any item that owes nothing.
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("distinct_multiplicity_table_top verification clean");
        else
            $display("distinct_multiplicity_table_top verification failed");
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends here.
    initial
    begin
        #20_000_000;
        $display("distinct_multiplicity_table_top verification failed");
        $finish;
    end

endmodule

// ===== distinct_multiplicity_table_top.f =====
+incdir+rtl
rtl/dmt_pkg.sv
rtl/dmt_front.sv
rtl/dmt_back.sv
rtl/distinct_multiplicity_table_top.sv
tb/distinct_multiplicity_table_top_tb.sv
